// File: hdl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Types and constants for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int RAU_WIDTH = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } rau_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_FIN,
    ST_DONE
  } rau_state_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] a_numerator;
    logic [30:0]        a_denominator;
    logic signed [31:0] b_numerator;
    logic [30:0]        b_denominator;
  } rau_in_t;

  typedef struct packed {
    logic signed [31:0] result_numerator;
    logic [30:0]        result_denominator;
    logic               first_less;
    logic               both_equal;
    logic               divide_by_zero;
    logic               overflow;
  } rau_out_t;

endpackage

// File: hdl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Add, subtract, multiply or divide two fractions, reduce and compare.
// ----------------------------------------------------------------------------
// One word runs four passes through one shared WIDTH x WIDTH multiplier, a
// binary gcd that uses one double-width subtractor a step, and two
// bit-serial double-width divisions by the gcd in one shared divider.
// A zero numerator or a divide by zero skips the gcd and the divisions.
// The input stalls while a word is in work; a finished result sits in an
// output register so the next word can be taken while it waits.
module rational_arithmetic_unit #(
  parameter int WIDTH = rau_pkg::RAU_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  rau_pkg::rau_in_t in_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rau_pkg::rau_out_t out_word_o
);

  import rau_pkg::*;

  localparam int PW = 2 * WIDTH;
  localparam int KW = $clog2(PW + 1);
  localparam logic [PW-1:0] HALF = PW'(1) << (WIDTH - 1);

  rau_state_e state_q, state_d;
  logic [1:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  rau_out_t   out_q, out_d;

  logic [1:0]              op_q, op_d;
  logic signed [WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
  logic signed [WIDTH-1:0] an_d, ad_d, bn_d, bd_d;
  logic signed [PW-1:0]    lhs_q, rhs_q, nn_q, dd_q;
  logic signed [PW-1:0]    lhs_d, rhs_d, nn_d, dd_d;
  logic [PW-1:0]           nm_q, nm_d, dm_q, dm_d;
  logic [PW-1:0]           x_q, x_d, y_q, y_d, g_q, g_d;
  logic [KW-1:0]           k_q, k_d;
  logic [PW-1:0]           qn_q, qn_d;
  logic                    neg_q, neg_d;
  logic signed [31:0]      rn_q, rn_d;
  logic [30:0]             rd_q, rd_d;
  logic                    less_q, less_d, eq_q, eq_d, dz_q, dz_d, ovf_q, ovf_d;

  logic signed [WIDTH-1:0] ma, mb;
  logic signed [PW-1:0]    prod;
  logic signed [PW-1:0]    num_c, den_c;
  logic [PW:0]             gdiff;
  logic [PW-1:0]           rn_pw;
  logic [WIDTH-2:0]        ad_raw, bd_raw;
  logic                    div_start;
  logic [PW-1:0]           div_dividend, div_divisor, div_quo;
  logic                    div_done;
  logic                    in_acc, out_load;

  rau_div #(.PW(PW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // shared multiplier
  always_comb begin
    case (step_q)
      2'd0:    begin ma = an_q; mb = bd_q; end
      2'd1:    begin ma = bn_q; mb = ad_q; end
      2'd2:    begin ma = an_q; mb = bn_q; end
      default: begin ma = ad_q; mb = bd_q; end
    endcase
    prod = PW'(ma) * PW'(mb);
  end

  always_comb begin
    case (op_q)
      OP_ADD:  begin num_c = lhs_q + rhs_q; den_c = dd_q;  end
      OP_SUB:  begin num_c = lhs_q - rhs_q; den_c = dd_q;  end
      OP_MUL:  begin num_c = nn_q;          den_c = dd_q;  end
      default: begin num_c = lhs_q;         den_c = rhs_q; end
    endcase
  end

  assign gdiff  = {1'b0, x_q} - {1'b0, y_q};
  assign ad_raw = in_word_i.a_denominator[WIDTH-2:0];
  assign bd_raw = in_word_i.b_denominator[WIDTH-2:0];
  assign in_acc = in_valid_i && (state_q == ST_IDLE);
  assign rn_pw  = neg_q ? PW'(-qn_q) : qn_q;

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    op_d         = op_q;
    an_d = an_q; ad_d = ad_q; bn_d = bn_q; bd_d = bd_q;
    lhs_d = lhs_q; rhs_d = rhs_q; nn_d = nn_q; dd_d = dd_q;
    nm_d = nm_q; dm_d = dm_q; x_d = x_q; y_d = y_q; g_d = g_q; k_d = k_q;
    qn_d = qn_q; neg_d = neg_q; rn_d = rn_q; rd_d = rd_q;
    less_d = less_q; eq_d = eq_q; dz_d = dz_q; ovf_d = ovf_q;
    div_start    = 1'b0;
    div_dividend = nm_q;
    div_divisor  = y_q << k_q;
    out_load     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_d = in_word_i.operation;
          an_d = in_word_i.a_numerator[WIDTH-1:0];
          bn_d = in_word_i.b_numerator[WIDTH-1:0];
          ad_d = (ad_raw == '0) ? WIDTH'(1) : {1'b0, ad_raw};
          bd_d = (bd_raw == '0) ? WIDTH'(1) : {1'b0, bd_raw};
          step_d  = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        case (step_q)
          2'd0:    lhs_d = prod;
          2'd1:    rhs_d = prod;
          2'd2:    nn_d  = prod;
          default: dd_d  = prod;
        endcase
        step_d = step_q + 1'b1;
        if (step_q == 2'd3) state_d = ST_PREP;
      end
      ST_PREP: begin
        less_d = lhs_q < rhs_q;
        eq_d   = lhs_q == rhs_q;
        dz_d   = (op_q == OP_DIV) && (bn_q == '0);
        neg_d  = num_c[PW-1] ^ den_c[PW-1];
        nm_d   = num_c[PW-1] ? PW'(-num_c) : num_c;
        dm_d   = den_c[PW-1] ? PW'(-den_c) : den_c;
        x_d    = nm_d;
        y_d    = dm_d;
        k_d    = '0;
        rn_d   = '0;
        rd_d   = 31'd1;
        ovf_d  = 1'b0;
        if (dz_d || num_c == '0) state_d = ST_DONE;
        else                     state_d = ST_GCD;
      end
      ST_GCD: begin
        if (x_q == '0) begin
          // gcd = y * 2^k
          g_d       = div_divisor;
          div_start = 1'b1;
          state_d   = ST_DIVN;
        end else if (!x_q[0] && !y_q[0]) begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          k_d = k_q + 1'b1;
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (gdiff[PW]) begin
          x_d = PW'(-gdiff);
          y_d = x_q;
        end else begin
          x_d = gdiff[PW-1:0];
        end
      end
      ST_DIVN: begin
        div_dividend = dm_q;
        div_divisor  = g_q;
        if (div_done) begin
          qn_d      = div_quo;
          div_start = 1'b1;
          state_d   = ST_DIVD;
        end
      end
      ST_DIVD: begin
        if (div_done) state_d = ST_FIN;
      end
      ST_FIN: begin
        // div_quo still holds the reduced denominator
        ovf_d = (div_quo > HALF - 1'b1) ||
                (neg_q ? (qn_q > HALF) : (qn_q > HALF - 1'b1));
        if (ovf_d) begin
          rn_d = '0;
          rd_d = 31'd1;
        end else begin
          rn_d = 32'(signed'(rn_pw));
          rd_d = 31'(div_quo);
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (out_load) begin
      out_valid_d                   = 1'b1;
      out_d.result_numerator        = rn_q;
      out_d.result_denominator      = rd_q;
      out_d.first_less              = less_q;
      out_d.both_equal              = eq_q;
      out_d.divide_by_zero          = dz_q;
      out_d.overflow                = ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    an_q <= an_d; ad_q <= ad_d; bn_q <= bn_d; bd_q <= bd_d;
    lhs_q <= lhs_d; rhs_q <= rhs_d; nn_q <= nn_d; dd_q <= dd_d;
    nm_q <= nm_d; dm_q <= dm_d; x_q <= x_d; y_q <= y_d; g_q <= g_d; k_q <= k_d;
    qn_q <= qn_d; neg_q <= neg_d; rn_q <= rn_d; rd_q <= rd_d;
    less_q <= less_d; eq_q <= eq_d; dz_q <= dz_d; ovf_q <= ovf_d;
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// File: hdl/rau_div.sv
// ----------------------------------------------------------------------------
// rau_div
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div #(
  parameter int PW = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [PW-1:0] dividend_i,
  input  logic [PW-1:0] divisor_i,
  output logic          done_o,
  output logic [PW-1:0] quotient_o
);

  localparam int CW = $clog2(PW);

  logic [PW:0]   rem_q, rem_d;
  logic [PW-1:0] quo_q, quo_d;
  logic [PW-1:0] dv_q, dv_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [PW:0]   shifted;
  logic [PW:0]   diff;

  always_comb begin
    shifted = {rem_q[PW-1:0], quo_q[PW-1]};
    diff    = shifted - {1'b0, dv_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    dv_d    = dv_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dv_d   = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[PW]) begin
        rem_d = diff;
        quo_d = {quo_q[PW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[PW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(PW-1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dv_q  <= dv_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: hdl/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_port_checker
// Port-level checks for the rational arithmetic unit, bound to the top.
// ----------------------------------------------------------------------------
module rau_port_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input rau_pkg::rau_in_t  in_word_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input rau_pkg::rau_out_t out_word_o
);

  // one word at a time: the input stalls right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("stalled result changed");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.divide_by_zero) |->
      (out_word_o.result_numerator == 32'sd0 && out_word_o.result_denominator == 31'd1
       && !out_word_o.overflow))
    else $error("divide by zero result not 0/1");

  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.overflow) |->
      (out_word_o.result_numerator == 32'sd0 && out_word_o.result_denominator == 31'd1))
    else $error("overflow result not 0/1");

  a_cmp_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_word_o.first_less && out_word_o.both_equal)
                    && out_word_o.result_denominator != 31'd0)
    else $error("inconsistent compare or zero denominator");

endmodule

bind rational_arithmetic_unit rau_port_checker u_rau_checker (.*);
